// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ODOH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odoh assertion failed");

// condition never holds
`define ODOH_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("odoh assertion failed");

`endif

// ----- hw/rtl/odoh_pkg.sv -----
// types and constants of the config list parser
// no dependencies

package odoh_pkg;

   localparam int KEY_BUFFER_BYTES_DEFAULT = 32;
   localparam int KEY_CAP_MAX              = 32;
   localparam int KEY_IDX_W                = 5;
   localparam int POS_W                    = 18;
   localparam int LIST_END_W               = 17;
   localparam logic [15:0] BODY_HEAD       = 16'd8;
   localparam logic [15:0] SUITE_BYTES     = 16'd6;
   localparam logic [15:0] HDR_LAST        = 16'd3;
   localparam logic [15:0] VERSION_ONE     = 16'd1;
   localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

   typedef enum logic [2:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_HEADER,
      PH_BODY,
      PH_DONE
   } phase_type;

   // one accepted record waiting for emission
   typedef struct packed {
      logic [15:0]          kem_id;
      logic [15:0]          kdf_id;
      logic [15:0]          aead_id;
      logic [15:0]          key_length;
      logic                 clipped;
      logic                 empty;
      logic [KEY_IDX_W-1:0] last_idx;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic                 en;
      logic [KEY_IDX_W-1:0] idx;
      logic [7:0]           data;
   } key_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic                 rd_en;
      logic [KEY_IDX_W-1:0] rd_idx;
      logic                 pop;
   } back_ctl_type;

endpackage

// ----- hw/rtl/odoh_if.sv -----
// request and response channel interfaces
// no dependencies

interface odoh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface odoh_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] kem_id;
   logic [15:0] kdf_id;
   logic [15:0] aead_id;
   logic [15:0] key_length;
   logic [7:0]  key_byte;
   logic [4:0]  byte_index;
   logic        byte_valid;
   logic        key_clipped;
   logic        last_of_record;

   modport source (output valid, kem_id, kdf_id, aead_id, key_length, key_byte,
                   byte_index, byte_valid, key_clipped, last_of_record,
                   input ready);
   modport sink   (input valid, kem_id, kdf_id, aead_id, key_length, key_byte,
                   byte_index, byte_valid, key_clipped, last_of_record,
                   output ready);
endinterface

// ----- hw/rtl/odoh_config_list_parser.sv -----
// top level of the config list parser: front end, record queue, back end
// depends on odoh_pkg, odoh_if, odoh_front, odoh_queue, odoh_back, assert_macros.svh
//
//   channel   dir   payload                                        handshake
//   req_bus   in    data_byte, end_of_message                      valid / ready
//   rsp_bus   out   kem_id .. aead_id, key_length, key_byte,       valid / ready
//                   byte_index, byte_valid, key_clipped,
//                   last_of_record
//
// one request byte per cycle while req_bus.ready is high; an accepted record gives
// one response per key byte (or one for an empty key), one per cycle while the
// response side is ready, via key buffer read, then response register
// req_bus.ready drops while two finished records wait in the queue
// reset is synchronous and clears control state only; no clearing pass
// response stalls back up only into the two-entry queue, never into parsing directly

`include "assert_macros.svh"

module odoh_config_list_parser
   import odoh_pkg::*;
#(
   parameter int KEY_BUFFER_BYTES = KEY_BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   odoh_req_if.sink   req_bus,
   odoh_rsp_if.source rsp_bus
);

   // front to queue: finished record descriptor and key byte writes
   push_type     push;
   key_wr_type   key_wr;
   // queue status seen by both sides
   q_status_type q_stat;
   // back to queue: key buffer read and pop
   back_ctl_type back_ctl;
   desc_type     head;
   logic [7:0]   rd_data;

   // front end parses the byte stream and judges each record
   odoh_front #(
      .KEY_BUFFER_BYTES (KEY_BUFFER_BYTES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_stat (q_stat),
      .push   (push),
      .key_wr (key_wr)
   );

   // two records in flight, each with its own key bank
   odoh_queue #(
      .KEY_BUFFER_BYTES (KEY_BUFFER_BYTES)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .key_wr   (key_wr),
      .back_ctl (back_ctl),
      .q_stat   (q_stat),
      .head     (head),
      .rd_data  (rd_data)
   );

   // back end walks the head record out through the response register
   odoh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head     (head),
      .rd_data  (rd_data),
      .back_ctl (back_ctl),
      .rsp      (rsp_bus)
   );

   // a record is never pushed into a full queue, nor popped from an empty one
   `ODOH_ASSERT_NEVER(a_push_full, clock, reset, push.valid && q_stat.full)
   `ODOH_ASSERT_NEVER(a_pop_empty, clock, reset, back_ctl.pop && q_stat.empty)
   // an empty key gives exactly one response, which closes the record
   `ODOH_ASSERT_IMP(a_empty_last, clock, reset, rsp_bus.valid && !rsp_bus.byte_valid, rsp_bus.last_of_record)

endmodule

// ----- hw/rtl/odoh_front.sv -----
// front end: byte parser of the config list, writes key bytes and pushes records
// depends on odoh_pkg and odoh_if

module odoh_front
   import odoh_pkg::*;
#(
   parameter int KEY_BUFFER_BYTES = KEY_BUFFER_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   odoh_req_if.sink     req,
   input  q_status_type q_stat,
   output push_type     push,
   output key_wr_type   key_wr
);

   localparam int KeyCap = (KEY_BUFFER_BYTES < KEY_CAP_MAX) ? KEY_BUFFER_BYTES : KEY_CAP_MAX;

   phase_type             phase_ff, phase_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [LIST_END_W-1:0] list_end_ff, list_end_in;
   logic [15:0]           version_ff, version_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           count_ff, count_in;
   logic [47:0]           suite_ff, suite_in;
   logic [15:0]           key_len_ff, key_len_in;

   logic        take;
   logic [7:0]  b;
   logic        eom;
   logic [15:0] cnt_inc;
   logic [15:0] key_off;
   logic        hdr_ok;
   logic        hdr_full;
   logic        body_done;
   logic        rec_ok;
   logic        clipped;

   assign req.ready = !q_stat.full;
   assign take      = req.valid && req.ready;
   assign b         = req.data_byte;
   assign eom       = req.end_of_message;
   assign cnt_inc   = count_ff + 16'd1;
   assign key_off   = count_ff - BODY_HEAD;
   assign hdr_full  = (count_ff == HDR_LAST);
   assign body_done = (cnt_inc == length_ff);

   // room for a full header before the list end, from the next byte on
   assign hdr_ok = ({1'b0, pos_ff} + 19'd5) <= {2'b00, list_end_in};

   assign rec_ok = (version_ff == VERSION_ONE) && (length_ff >= BODY_HEAD) &&
                   (({1'b0, key_len_in} + {1'b0, BODY_HEAD}) <= {1'b0, length_ff});
   assign clipped = key_len_in > 16'(KeyCap);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_LEN_HI: phase_in = PH_LEN_LO;
            PH_LEN_LO: phase_in = hdr_ok ? PH_HEADER : PH_DONE;
            PH_HEADER: begin
               if (hdr_full) begin
                  if (length_in == 16'd0) begin
                     phase_in = hdr_ok ? PH_HEADER : PH_DONE;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (body_done) begin
                  phase_in = hdr_ok ? PH_HEADER : PH_DONE;
               end
            end
            default: phase_in = PH_DONE;
         endcase
         if (eom) begin
            phase_in = PH_LEN_HI;
         end
      end
   end

   // next values of the field registers
   always_comb begin
      list_end_in = list_end_ff;
      version_in  = version_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      suite_in    = suite_ff;
      key_len_in  = key_len_ff;
      pos_in      = pos_ff;
      case (phase_ff)
         PH_LEN_HI: list_end_in = {1'b0, b, 8'h00};
         PH_LEN_LO: list_end_in = {1'b0, list_end_ff[15:8], b} + 17'd2;
         PH_HEADER: begin
            if (count_ff < 16'd2) begin
               version_in = {version_ff[7:0], b};
            end else begin
               length_in = {length_ff[7:0], b};
            end
         end
         PH_BODY: begin
            if (count_ff < SUITE_BYTES) begin
               suite_in = {suite_ff[39:0], b};
            end else if (count_ff < BODY_HEAD) begin
               key_len_in = {key_len_ff[7:0], b};
            end
         end
         default: ;
      endcase
      if (take) begin
         case (phase_ff)
            PH_LEN_LO: begin
               count_in   = 16'd0;
               version_in = 16'd0;
               length_in  = 16'd0;
            end
            PH_HEADER: begin
               count_in = cnt_inc;
               if (hdr_full) begin
                  count_in = 16'd0;
                  if (length_in == 16'd0) begin
                     version_in = 16'd0;
                  end else begin
                     suite_in   = 48'd0;
                     key_len_in = 16'd0;
                  end
               end
            end
            PH_BODY: begin
               count_in = cnt_inc;
               if (body_done) begin
                  count_in   = 16'd0;
                  version_in = 16'd0;
                  length_in  = 16'd0;
               end
            end
            default: ;
         endcase
         if (eom) begin
            count_in = 16'd0;
            pos_in   = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      push.valid           = take && (phase_ff == PH_BODY) && body_done && rec_ok;
      push.desc.kem_id     = suite_in[47:32];
      push.desc.kdf_id     = suite_in[31:16];
      push.desc.aead_id    = suite_in[15:0];
      push.desc.key_length = key_len_in;
      push.desc.clipped    = clipped;
      push.desc.empty      = (key_len_in == 16'd0);
      if (key_len_in == 16'd0) begin
         push.desc.last_idx = '0;
      end else if (clipped) begin
         push.desc.last_idx = KEY_IDX_W'(KeyCap - 1);
      end else begin
         push.desc.last_idx = KEY_IDX_W'(key_len_in - 16'd1);
      end
      key_wr.en   = take && (phase_ff == PH_BODY) && (count_ff >= BODY_HEAD) &&
                    (key_off < 16'(KeyCap));
      key_wr.idx  = key_off[KEY_IDX_W-1:0];
      key_wr.data = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN_HI;
         pos_ff      <= '0;
         list_end_ff <= '0;
         version_ff  <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         suite_ff    <= '0;
         key_len_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (take) begin
            pos_ff      <= pos_in;
            list_end_ff <= list_end_in;
            version_ff  <= version_in;
            length_ff   <= length_in;
            count_ff    <= count_in;
            suite_ff    <= suite_in;
            key_len_ff  <= key_len_in;
         end
      end
   end

endmodule

// ----- hw/rtl/odoh_queue.sv -----
// two-entry record queue with a key buffer bank per entry
// depends on odoh_pkg

module odoh_queue
   import odoh_pkg::*;
#(
   parameter int KEY_BUFFER_BYTES = KEY_BUFFER_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  key_wr_type   key_wr,
   input  back_ctl_type back_ctl,
   output q_status_type q_stat,
   output desc_type     head,
   output logic [7:0]   rd_data
);

   localparam int KeyCap = (KEY_BUFFER_BYTES < KEY_CAP_MAX) ? KEY_BUFFER_BYTES : KEY_CAP_MAX;
   localparam int IdxW   = (KeyCap > 1) ? $clog2(KeyCap) : 1;

   desc_type   desc_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic [7:0] key_mem [2][KeyCap];
   logic [7:0] rd_data_ff;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign head         = desc_ff[rd_ptr_ff];
   assign rd_data      = rd_data_ff;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         desc_ff[wr_ptr_ff] <= push.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (key_wr.en) begin
         key_mem[wr_ptr_ff][key_wr.idx[IdxW-1:0]] <= key_wr.data;
      end
      if (back_ctl.rd_en) begin
         rd_data_ff <= key_mem[rd_ptr_ff][back_ctl.rd_idx[IdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (back_ctl.pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push.valid} - {1'b0, back_ctl.pop};
      end
   end

endmodule

// ----- hw/rtl/odoh_back.sv -----
// back end: walks the head record's key bytes into the response register
// depends on odoh_pkg and odoh_if

module odoh_back
   import odoh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_stat,
   input  desc_type     head,
   input  logic [7:0]   rd_data,
   output back_ctl_type back_ctl,
   odoh_rsp_if.source   rsp
);

   logic [KEY_IDX_W-1:0] issue_k_ff, issue_k_in;
   logic                 issued_all_ff, issued_all_in;
   logic                 f_valid_ff, f_valid_in;
   logic [KEY_IDX_W-1:0] f_k_ff;
   logic                 out_valid_ff, out_valid_in;

   logic [15:0]          kem_ff, kdf_ff, aead_ff, klen_ff;
   logic [7:0]           kbyte_ff;
   logic [KEY_IDX_W-1:0] bidx_ff;
   logic                 bvalid_ff, clip_ff, last_ff;

   logic load, issue, f_last, issue_last;

   assign load       = f_valid_ff && (!out_valid_ff || rsp.ready);
   assign issue      = !q_stat.empty && !issued_all_ff && (!f_valid_ff || load);
   assign f_last     = (f_k_ff == head.last_idx);
   assign issue_last = (issue_k_ff == head.last_idx);

   assign back_ctl.rd_en  = issue;
   assign back_ctl.rd_idx = issue_k_ff;
   assign back_ctl.pop    = load && f_last;

   always_comb begin
      issue_k_in    = issue_k_ff;
      issued_all_in = issued_all_ff;
      f_valid_in    = f_valid_ff;
      out_valid_in  = out_valid_ff;
      if (issue) begin
         issue_k_in    = issue_last ? '0 : issue_k_ff + 1'b1;
         issued_all_in = issue_last;
      end else if (back_ctl.pop) begin
         issued_all_in = 1'b0;
      end
      if (issue) begin
         f_valid_in = 1'b1;
      end else if (load) begin
         f_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_k_ff    <= '0;
         issued_all_ff <= 1'b0;
         f_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         issue_k_ff    <= issue_k_in;
         issued_all_ff <= issued_all_in;
         f_valid_ff    <= f_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         f_k_ff <= issue_k_ff;
      end
      if (load) begin
         kem_ff    <= head.kem_id;
         kdf_ff    <= head.kdf_id;
         aead_ff   <= head.aead_id;
         klen_ff   <= head.key_length;
         kbyte_ff  <= head.empty ? 8'd0 : rd_data;
         bidx_ff   <= head.empty ? '0 : f_k_ff;
         bvalid_ff <= !head.empty;
         clip_ff   <= head.clipped;
         last_ff   <= f_last;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kem_id         = kem_ff;
   assign rsp.kdf_id         = kdf_ff;
   assign rsp.aead_id        = aead_ff;
   assign rsp.key_length     = klen_ff;
   assign rsp.key_byte       = kbyte_ff;
   assign rsp.byte_index     = bidx_ff;
   assign rsp.byte_valid     = bvalid_ff;
   assign rsp.key_clipped    = clip_ff;
   assign rsp.last_of_record = last_ff;

endmodule

// ----- tb/odoh_parser_checker.sv -----
// response checker for the config list parser: follows the request bytes, predicts
// the key responses and compares them with what leaves the block
// depends on odoh_pkg and the odoh_req_if / odoh_rsp_if interfaces
`timescale 1ns / 100ps

module odoh_parser_checker
   import odoh_pkg::*;
#(
   parameter int KEY_BUFFER_BYTES = KEY_BUFFER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   odoh_req_if         req_bus,
   odoh_rsp_if         rsp_bus,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam int KEY_CAP     = (KEY_BUFFER_BYTES < KEY_CAP_MAX) ? KEY_BUFFER_BYTES : KEY_CAP_MAX;
   localparam int PRINT_LIMIT = 60;

   typedef struct packed {
      logic [15:0] kem_id;
      logic [15:0] kdf_id;
      logic [15:0] aead_id;
      logic [15:0] key_length;
      logic [7:0]  key_byte;
      logic [4:0]  byte_index;
      logic        byte_valid;
      logic        key_clipped;
      logic        last_of_record;
   } key_rsp_type;

   key_rsp_type             expected_keys[$];

   phase_type               phase;
   logic [POS_W-1:0]        msg_pos;
   logic [LIST_END_W-1:0]   list_end;
   logic [15:0]             rec_version;
   logic [15:0]             rec_length;
   logic [15:0]             body_count;
   logic [47:0]             suite;
   logic [15:0]             key_len;
   logic [7:0]              key_buf [KEY_CAP];

   function automatic void clear_parser();
      phase       = PH_LEN_HI;
      msg_pos     = '0;
      list_end    = '0;
      rec_version = '0;
      rec_length  = '0;
      body_count  = '0;
      suite       = '0;
      key_len     = '0;
   endfunction

   // a header only starts if all four of its bytes lie inside the list
   function automatic void next_record(input int unsigned next_pos);
      body_count  = '0;
      rec_version = '0;
      rec_length  = '0;
      phase = (next_pos + 4 <= list_end) ? PH_HEADER : PH_DONE;
   endfunction

   function automatic void queue_record_keys();
      int unsigned count;
      logic        clipped;
      key_rsp_type r;
      clipped = int'(key_len) > KEY_CAP;
      if (key_len == 0)
         count = 1;
      else
         count = clipped ? KEY_CAP : int'(key_len);
      for (int unsigned k = 0; k < count; k++) begin
         r.kem_id         = suite[47:32];
         r.kdf_id         = suite[31:16];
         r.aead_id        = suite[15:0];
         r.key_length     = key_len;
         r.byte_valid     = key_len != 0;
         r.key_byte       = r.byte_valid ? key_buf[k] : 8'h00;
         r.byte_index     = r.byte_valid ? 5'(k) : 5'd0;
         r.key_clipped    = clipped;
         r.last_of_record = (k + 1 == count);
         expected_keys.insert(expected_keys.size(), r);
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic eom);
      int unsigned pos;
      int unsigned k;
      pos = 32'(msg_pos);
      case (phase)
         PH_LEN_HI: begin
            list_end = {1'b0, b, 8'h00};
            phase    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            list_end = (list_end | LIST_END_W'(b)) + LIST_END_W'(2);
            next_record(pos + 1);
         end
         PH_HEADER: begin
            if (body_count < 2)
               rec_version = {rec_version[7:0], b};
            else
               rec_length = {rec_length[7:0], b};
            body_count = body_count + 16'd1;
            if (body_count == 16'd4) begin
               if (rec_length == 0) begin
                  next_record(pos + 1);
               end else begin
                  phase      = PH_BODY;
                  body_count = '0;
                  suite      = '0;
                  key_len    = '0;
               end
            end
         end
         PH_BODY: begin
            k = 32'(body_count);
            if (k < 6)
               suite = {suite[39:0], b};
            else if (k < 8)
               key_len = {key_len[7:0], b};
            else if (k - 8 < KEY_CAP)
               key_buf[k - 8] = b;
            body_count = body_count + 16'd1;
            if (body_count == rec_length) begin
               if (rec_version == VERSION_ONE && rec_length >= BODY_HEAD &&
                   int'(BODY_HEAD) + int'(key_len) <= int'(rec_length))
                  queue_record_keys();
               next_record(pos + 1);
            end
         end
         default: phase = PH_DONE;
      endcase
      if (eom) begin
         phase      = PH_LEN_HI;
         msg_pos    = '0;
         body_count = '0;
      end else if (msg_pos != POS_MAX) begin
         msg_pos = msg_pos + 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT)
         $display("[%0t] checker: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   task automatic check_response();
      key_rsp_type want;
      if (expected_keys.size() == 0) begin
         report_mismatch("response while no key byte is outstanding");
      end else begin
         want = expected_keys.pop_front();
         compare_field("kem_id", rsp_bus.kem_id, want.kem_id);
         compare_field("kdf_id", rsp_bus.kdf_id, want.kdf_id);
         compare_field("aead_id", rsp_bus.aead_id, want.aead_id);
         compare_field("key_length", rsp_bus.key_length, want.key_length);
         compare_field("key_byte", 16'(rsp_bus.key_byte), 16'(want.key_byte));
         compare_field("byte_index", 16'(rsp_bus.byte_index), 16'(want.byte_index));
         compare_field("byte_valid", 16'(rsp_bus.byte_valid), 16'(want.byte_valid));
         compare_field("key_clipped", 16'(rsp_bus.key_clipped), 16'(want.key_clipped));
         compare_field("last_of_record", 16'(rsp_bus.last_of_record),
                       16'(want.last_of_record));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_keys.delete();
         fail_count = 0;
         pending   <= 0;
      end else begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            parse_byte(req_bus.data_byte, req_bus.end_of_message);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_response();
         pending <= expected_keys.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// top of the config list parser testbench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict
// depends on odoh_pkg, odoh_if, the parser rtl and odoh_parser_checker
`timescale 1ns / 100ps

module testbench;
   import odoh_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no request or response moving
   localparam int SINK_HOLD      = 300;    // long back-pressure stretch on the response side
   localparam int SETTLE_CYCLES  = 20;

   logic        clock;
   logic        reset;
   logic        steady;       // no idling on either side while set
   logic        hold_ask;     // asks the response side for its long hold-off
   int unsigned fail_count;
   int unsigned pending;
   int unsigned quiet_cycles = 0;
   logic [7:0]  msg_bytes[$];

   odoh_req_if req_bus ();
   odoh_rsp_if rsp_bus ();

   odoh_config_list_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   odoh_parser_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // message building: records go into msg_bytes, the list length is put in
   // front just before the message is sent
   // ---------------------------------------------------------------------------

   function automatic logic [47:0] random_suite();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic void add_byte(input logic [7:0] value);
      msg_bytes.insert(msg_bytes.size(), value);
   endfunction

   // header, then the first eight body bytes carry the suite and key length,
   // anything beyond that is random key material or padding
   function automatic void add_record(input logic [15:0] version, input logic [15:0] rec_len,
                                      input int unsigned key_len, input logic [47:0] suite);
      logic [63:0] head;
      head = {suite, 16'(key_len)};
      add_byte(version[15:8]);
      add_byte(version[7:0]);
      add_byte(rec_len[15:8]);
      add_byte(rec_len[7:0]);
      for (int unsigned i = 0; i < rec_len; i++)
         add_byte(i < 8 ? head[63 - 8*i -: 8] : 8'($urandom_range(255)));
   endfunction

   function automatic logic [15:0] list_size();
      return 16'(msg_bytes.size());
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] value, input logic last);
      while (!steady && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= value;
      req_bus.end_of_message <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // drops the last cut bytes, so the end of message flag lands early
   task automatic send_message(input logic [15:0] list_len, input int unsigned cut);
      int unsigned n;
      msg_bytes.push_front(list_len[7:0]);
      msg_bytes.push_front(list_len[15:8]);
      n = msg_bytes.size() - cut;
      for (int unsigned i = 0; i < n; i++)
         send_byte(msg_bytes[i], i == n - 1);
      msg_bytes.delete();
   endtask

   // pending is a registered copy in the checker, so look only from the edge after the last request
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // response side: random idling, plus one long hold-off so that the record
   // queue fills and request ready drops
   // ---------------------------------------------------------------------------

   initial begin : sink_side
      int unsigned stall_left;
      logic        hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = SINK_HOLD;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: ends the run when nothing moves for too long
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout: nothing moved for %0d cycles, %0d key bytes outstanding",
               WATCHDOG_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   initial begin : stimulus
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'h00;
      req_bus.end_of_message <= 1'b0;
      steady                 <= 1'b0;
      hold_ask               <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sent under the long response hold-off: the empty key leaves through the
      // response register, the two good records near the end fill the record
      // queue, and the trailing header stalls the requests until the hold-off ends
      hold_ask <= 1'b1;

      // empty key: one response with byte_valid low, suite fields at both extremes
      add_record(VERSION_ONE, 16'd8, 0, {16'hFFFF, 16'h0000, 16'hFFFF});
      // rejected records are skipped: wrong version, too short, key overrunning
      // the record, zero length
      add_record(16'd2, 16'd8, 0, random_suite());
      add_record(VERSION_ONE, 16'd5, 0, random_suite());
      add_record(VERSION_ONE, 16'd8, 1, random_suite());
      add_record(VERSION_ONE, 16'd0, 0, random_suite());
      // a one-byte key, then a record whose body runs past the list end and is
      // still accepted, then a header that would start past the list end
      add_record(VERSION_ONE, 16'd9, 1, random_suite());
      add_record(VERSION_ONE, 16'd8, 0, random_suite());
      add_record(VERSION_ONE, 16'd8, 0, random_suite());
      send_message(16'd70, 0);

      // sender pause until every key byte has come back
      wait_drained();

      // key longer than the buffer: clipped to the capacity, flagged on every byte,
      // sent and drained with no idling on either side
      steady <= 1'b1;
      add_record(VERSION_ONE, 16'd41, 33, {16'h0000, 16'hFFFF, 16'h0001});
      send_message(list_size(), 0);
      wait_drained();
      steady <= 1'b0;

      // largest list length, message ends inside a body: the record is dropped
      add_record(VERSION_ONE, 16'd8, 0, random_suite());
      send_message(16'hFFFF, 3);

      // message ends inside a header
      add_record(VERSION_ONE, 16'd8, 0, random_suite());
      send_message(list_size(), 11);

      // end of message on the first length byte, then on the second
      send_message(16'hFFFF, 1);
      send_message(16'h0000, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
